// File: sv/ohs_pkg.sv
// Package for the open-addressing hash set: sizes, hash constants, codes,
// controller states and the command/status structs between ctrl and datapath.
// No dependencies.
package ohs_pkg;

    // Table geometry
    localparam int SLOTS      = 4096;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int KEY_W      = 64;
    localparam int LOAD_LIMIT = (SLOTS * 3) / 4;

    // Empty-slot marker, also the reserved key
    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

    // fmix64 constants
    localparam logic [KEY_W-1:0] FMIX_C1    = 64'hff51_afd7_ed55_8ccd;
    localparam logic [KEY_W-1:0] FMIX_C2    = 64'hc4ce_b9fe_1a85_ec53;
    localparam int               FMIX_SHIFT = 33;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_RESERVED = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_M1_LO,
        ST_M1_CR1,
        ST_M1_CR2,
        ST_M2_LO,
        ST_M2_CR1,
        ST_M2_CR2,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_WIPE,
        ST_DONE
    } state_t;

    // Partial-product step of a 64x64 (mod 2^64) multiply on one 32x32 unit
    typedef enum logic [1:0] {
        MUL_LO,
        MUL_CR1,
        MUL_CR2
    } mul_step_t;

    typedef enum logic [2:0] {
        RES_NEW,
        RES_FOUND,
        RES_FULL,
        RES_RESERVED,
        RES_CLEAR
    } res_kind_t;

    typedef struct packed {
        logic       accept;
        logic       mul_en;
        mul_step_t  mul_step;
        logic       mul_c2;
        logic       load_idx;
        logic       mem_rd;
        logic       probe_adv;
        logic       store;
        logic       sweep_en;
        logic       occ_clr;
        logic       res_load;
        res_kind_t  res_kind;
        logic       push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic is_reserved;
        logic at_limit;
        logic hit_empty;
        logic hit_key;
        logic probe_last;
        logic sweep_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: sv/open_addressing_hash_set_top.sv
// Open-addressing hash set of 64-bit keys: linear probing on fmix64 hashes.
// Top level; depends on ohs_pkg, ohs_ctrl and ohs_dpath.
//
// Input channel (in_valid/in_stall, operation, key): operation 0 inserts key,
// operation 1 empties the table. One item is worked on at a time; in_stall is
// low only while the block is idle.
// Output channel (out_valid/out_stall, is_new, status, slot_index, fill_count):
// one result per item, held in an output register, so the next item is taken
// while a result waits.
// Each insert runs fmix64 on one shared 32x32 multiplier (three partial
// products per 64-bit multiply), then probes; each probe is a registered
// memory read and a compare. A reserved key or a refusal at the load limit
// skips the hash and the probes. A clear writes every slot through the
// single write port.
// Reset: after rst_n rises the block wipes all SLOTS (4096) slots, one per
// cycle, with in_stall high; it then goes idle with an empty table.
// A stalled receiver holds the result; a finished item waits in a pending
// register until the output register is free.
module open_addressing_hash_set_top
    import ohs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [KEY_W-1:0]  key,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              is_new,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] slot_index,
    output logic [CNT_W-1:0]  fill_count
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    ohs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ohs_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .operation  (operation),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_new     (is_new),
        .status     (status),
        .slot_index (slot_index),
        .fill_count (fill_count)
    );

    // Busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken twice in a row");

    // Occupancy never passes the load limit
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_count <= CNT_W'(LOAD_LIMIT)))
        else $error("fill count above load limit");

    // A new key always leaves a nonzero fill count and ok status
    a_new_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_new) |-> (status == STATUS_OK && fill_count != '0))
        else $error("new key with bad status or empty table");

    // Refused or rejected inserts report no slot
    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> (!is_new && slot_index == '0))
        else $error("refused insert reports a slot");

endmodule

// File: sv/ohs_ctrl.sv
// Controller state machine for the hash set: sequences hashing, probing,
// table wipes and result hand-off. Depends on ohs_pkg.
module ohs_ctrl
    import ohs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the wipe of the slot store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.is_clear)
                begin
                    state_next = ST_WIPE;
                end
                else if (stat.is_reserved || stat.at_limit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_M1_LO;
                end
            end
            ST_M1_LO:     state_next = ST_M1_CR1;
            ST_M1_CR1:    state_next = ST_M1_CR2;
            ST_M1_CR2:    state_next = ST_M2_LO;
            ST_M2_LO:     state_next = ST_M2_CR1;
            ST_M2_CR1:    state_next = ST_M2_CR2;
            ST_M2_CR2:    state_next = ST_PROBE_RD;
            ST_PROBE_RD:  state_next = ST_PROBE_CHK;
            ST_PROBE_CHK:
            begin
                if (stat.hit_empty || stat.hit_key || stat.probe_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_WIPE:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_INIT;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.mul_step = MUL_LO;
        cmd.res_kind = RES_CLEAR;
        in_stall     = (state_reg != ST_IDLE);

        cmd.mul_en = state_reg inside {ST_M1_LO, ST_M1_CR1, ST_M1_CR2,
                                       ST_M2_LO, ST_M2_CR1, ST_M2_CR2};
        cmd.mul_c2 = state_reg inside {ST_M2_LO, ST_M2_CR1, ST_M2_CR2};

        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_en = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.accept = in_valid;
            end
            ST_CHECK:
            begin
                if (!stat.is_clear && stat.is_reserved)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_RESERVED;
                end
                else if (!stat.is_clear && stat.at_limit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_FULL;
                end
            end
            ST_M1_LO, ST_M2_LO:
            begin
                cmd.mul_step = MUL_LO;
            end
            ST_M1_CR1, ST_M2_CR1:
            begin
                cmd.mul_step = MUL_CR1;
            end
            ST_M1_CR2:
            begin
                cmd.mul_step = MUL_CR2;
            end
            ST_M2_CR2:
            begin
                cmd.mul_step = MUL_CR2;
                cmd.load_idx = 1'b1;
            end
            ST_PROBE_RD:
            begin
                cmd.mem_rd = 1'b1;
            end
            ST_PROBE_CHK:
            begin
                if (stat.hit_empty)
                begin
                    cmd.store    = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_NEW;
                end
                else if (stat.hit_key)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_FOUND;
                end
                else if (stat.probe_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_FULL;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                end
            end
            ST_WIPE:
            begin
                cmd.sweep_en = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.occ_clr  = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_CLEAR;
                end
            end
            ST_DONE:
            begin
                cmd.push = stat.out_free;
            end
            default:
            begin
                cmd.sweep_en = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/ohs_dpath.sv
// Datapath for the hash set: fmix64 on one shared 32x32 multiplier, the slot
// store memory, probe index/counter, occupancy and the output register.
// Depends on ohs_pkg.
module ohs_dpath
    import ohs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_stat_t          stat,
    input  logic              operation,
    input  logic [KEY_W-1:0]  key,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              is_new,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] slot_index,
    output logic [CNT_W-1:0]  fill_count
);

    // Slot store
    logic [KEY_W-1:0] mem [SLOTS];

    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  x_reg;
    logic [KEY_W-1:0]  plo_reg;
    logic [31:0]       acc_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0] sweep_reg;
    logic [CNT_W-1:0]  occ_reg;
    logic [KEY_W-1:0]  rd_reg;
    logic              res_new_reg;
    logic [1:0]        res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic              out_valid_reg;
    logic              out_new_reg;
    logic [1:0]        out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [CNT_W-1:0]  out_fill_reg;

    logic [KEY_W-1:0]  cconst;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       prod;
    logic [KEY_W-1:0]  mul_full;
    logic [KEY_W-1:0]  x_mixed;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [KEY_W-1:0]  mem_wdata;

    // Select operand halves for the current partial product
    always_comb
    begin
        cconst = cmd.mul_c2 ? FMIX_C2 : FMIX_C1;
        mul_a  = (cmd.mul_step == MUL_CR2) ? x_reg[63:32] : x_reg[31:0];
        mul_b  = (cmd.mul_step == MUL_CR1) ? cconst[63:32] : cconst[31:0];
    end

    assign prod     = 64'(mul_a) * 64'(mul_b);
    assign mul_full = {acc_reg + prod[31:0], plo_reg[31:0]};
    assign x_mixed  = mul_full ^ (mul_full >> FMIX_SHIFT);

    // Latch input, run the hash steps
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= operation;
            key_reg <= key;
            x_reg   <= key ^ (key >> FMIX_SHIFT);
        end
        else if (cmd.mul_en)
        begin
            case (cmd.mul_step)
                MUL_LO:  plo_reg <= prod;
                MUL_CR1: acc_reg <= plo_reg[63:32] + prod[31:0];
                MUL_CR2: x_reg   <= x_mixed;
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    // Probe index and step counter
    always_ff @(posedge clk)
    begin
        if (cmd.load_idx)
        begin
            idx_reg <= x_mixed[SLOT_W-1:0];
            cnt_reg <= '0;
        end
        else if (cmd.probe_adv)
        begin
            idx_reg <= idx_reg + 1'b1;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Sweep address and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            if (cmd.sweep_en)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.occ_clr)
            begin
                occ_reg <= '0;
            end
            else if (cmd.store)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
        end
    end

    // Single write port shared by the sweep and key stores
    assign mem_we    = cmd.sweep_en || cmd.store;
    assign mem_waddr = cmd.sweep_en ? sweep_reg : idx_reg;
    assign mem_wdata = cmd.sweep_en ? EMPTY_KEY : key_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    // Hold the pending result until the output register is free
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_kind)
                RES_NEW:
                begin
                    res_new_reg    <= 1'b1;
                    res_status_reg <= STATUS_OK;
                    res_slot_reg   <= idx_reg;
                end
                RES_FOUND:
                begin
                    res_new_reg    <= 1'b0;
                    res_status_reg <= STATUS_OK;
                    res_slot_reg   <= idx_reg;
                end
                RES_FULL:
                begin
                    res_new_reg    <= 1'b0;
                    res_status_reg <= STATUS_FULL;
                    res_slot_reg   <= '0;
                end
                RES_RESERVED:
                begin
                    res_new_reg    <= 1'b0;
                    res_status_reg <= STATUS_RESERVED;
                    res_slot_reg   <= '0;
                end
                default:
                begin
                    res_new_reg    <= 1'b0;
                    res_status_reg <= STATUS_OK;
                    res_slot_reg   <= '0;
                end
            endcase
        end
    end

    // Output register: load on push, drop once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_new_reg    <= res_new_reg;
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_fill_reg   <= occ_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_new     = out_new_reg;
    assign status     = out_status_reg;
    assign slot_index = out_slot_reg;
    assign fill_count = out_fill_reg;

    // Status back to the controller
    always_comb
    begin
        stat.is_clear    = (op_reg == OP_CLEAR);
        stat.is_reserved = (key_reg == EMPTY_KEY);
        stat.at_limit    = (occ_reg >= CNT_W'(LOAD_LIMIT));
        stat.hit_empty   = (rd_reg == EMPTY_KEY);
        stat.hit_key     = (rd_reg == key_reg);
        stat.probe_last  = (cnt_reg == CNT_W'(SLOTS - 1));
        stat.sweep_last  = (sweep_reg == SLOT_W'(SLOTS - 1));
        stat.out_free    = !out_valid_reg || !out_stall;
    end

endmodule

// File: sim/open_addressing_hash_set_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for open_addressing_hash_set_top: inserts and clears
// checked against a shadow copy of the probe table kept in the testbench.
// Depends on ohs_pkg and the open_addressing_hash_set_top RTL.
module open_addressing_hash_set_top_tb
    import ohs_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;  // longer than a full clear
    localparam int DRAIN_CYCLES   = 50;
    localparam int PHASE_ITEMS    = 150;    // random items per idling phase
    localparam int HOLD_CYCLES    = 400;
    localparam int POOL_MAX       = 256;

    typedef struct packed {
        logic              is_new;
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  fill;
    } set_result_t;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              operation  = OP_INSERT;
    logic [KEY_W-1:0]  key        = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              is_new;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  fill_count;

    // Shadow table and the results it predicts
    logic [KEY_W-1:0] shadow_slots [SLOTS];
    int unsigned      shadow_fill;
    set_result_t      expected_results [$];
    logic [KEY_W-1:0] key_pool [$];

    // Idling knobs; the stall process owns hold_cnt
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_len     = 0;
    int unsigned hold_cnt     = 0;
    int unsigned quiet_cycles = 0;

    int unsigned error_count    = 0;
    int unsigned checked_count  = 0;
    int unsigned sent_count     = 0;
    int unsigned new_count      = 0;
    int unsigned found_count    = 0;
    int unsigned full_count     = 0;
    int unsigned reserved_count = 0;
    int unsigned clear_count    = 0;

    open_addressing_hash_set_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .is_new     (is_new),
        .status     (status),
        .slot_index (slot_index),
        .fill_count (fill_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // MurmurHash3 64-bit finalizer; products wrap at 64 bits
    function automatic logic [KEY_W-1:0] mix64(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] x;
        x = v ^ (v >> FMIX_SHIFT);
        x = x * FMIX_C1;
        x = x ^ (x >> FMIX_SHIFT);
        x = x * FMIX_C2;
        x = x ^ (x >> FMIX_SHIFT);
        return x;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Search for a non-reserved key whose home slot is target
    function automatic logic [KEY_W-1:0] key_for_slot(input logic [SLOT_W-1:0] target);
        logic [KEY_W-1:0] cand;
        logic [KEY_W-1:0] h;
        cand = rand_key();
        h = mix64(cand);
        while (h[SLOT_W-1:0] != target || cand == EMPTY_KEY)
        begin
            cand = cand + 1;
            h = mix64(cand);
        end
        return cand;
    endfunction

    // Apply one operation to the shadow table and return the result it gives
    function automatic set_result_t apply_set_op(input logic op,
                                                 input logic [KEY_W-1:0] k_in);
        set_result_t      res;
        logic [KEY_W-1:0] h;
        logic [SLOT_W-1:0] pos;
        res = '0;
        if (op == OP_CLEAR)
        begin
            foreach (shadow_slots[i])
                shadow_slots[i] = EMPTY_KEY;
            shadow_fill = 0;
            res.status = STATUS_OK;
            clear_count++;
        end
        else if (k_in == EMPTY_KEY)
        begin
            res.status = STATUS_RESERVED;
            reserved_count++;
        end
        else if (shadow_fill * 4 >= SLOTS * 3)
        begin
            res.status = STATUS_FULL;
            full_count++;
        end
        else
        begin
            h = mix64(k_in);
            pos = h[SLOT_W-1:0];
            // stays FULL only if the probe runs through every slot
            res.status = STATUS_FULL;
            for (int n = 0; n < SLOTS; n++)
            begin
                if (shadow_slots[pos] == EMPTY_KEY)
                begin
                    shadow_slots[pos] = k_in;
                    shadow_fill++;
                    res.is_new = 1'b1;
                    res.status = STATUS_OK;
                    res.slot   = pos;
                    new_count++;
                    break;
                end
                if (shadow_slots[pos] == k_in)
                begin
                    res.status = STATUS_OK;
                    res.slot   = pos;
                    found_count++;
                    break;
                end
                pos = pos + 1'b1;  // wraps at SLOTS
            end
            if (res.status == STATUS_FULL)
                full_count++;
        end
        res.fill = shadow_fill[CNT_W-1:0];
        return res;
    endfunction

    // Offer one item, hold it until the transfer, then record its expected result
    task automatic send_item(input logic op, input logic [KEY_W-1:0] k_in);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k_in;
        do
            @(posedge clk);
        while (!(in_valid === 1'b1 && in_stall === 1'b0));
        expected_results.push_back(apply_set_op(op, k_in));
        sent_count++;
    endtask

    task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Drive receiver stall: a long hold when requested, else random
    always @(posedge clk)
    begin
        if (hold_cnt < hold_len)
        begin
            hold_cnt  <= hold_cnt + 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, status %0d slot %0d fill %0d",
                         $time, status, slot_index, fill_count);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                checked_count++;
                check_field("is_new", want.is_new, is_new);
                check_field("status", want.status, status);
                check_field("slot_index", want.slot, slot_index);
                check_field("fill_count", want.fill, fill_count);
            end
        end
    end

    // Abort when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, %0d cycles without a transfer, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, expected_results.size());
            $display("** open_addressing_hash_set_top: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Boundary keys, the reserved key and repeated inserts
    task automatic test_extreme_keys();
        set_idling(0, 0);
        send_item(OP_INSERT, 64'h0);
        send_item(OP_INSERT, 64'h1);
        send_item(OP_INSERT, 64'h8000_0000_0000_0000);
        send_item(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(OP_INSERT, EMPTY_KEY);
        send_item(OP_INSERT, 64'h0);
        send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFE);
    endtask

    // Collide keys on the last two slots so probes wrap to slot 0
    task automatic test_probe_wrap();
        logic [KEY_W-1:0] last_keys [4];
        logic [KEY_W-1:0] near_keys [2];
        foreach (last_keys[i])
            last_keys[i] = key_for_slot(SLOT_W'(SLOTS - 1));
        foreach (near_keys[i])
            near_keys[i] = key_for_slot(SLOT_W'(SLOTS - 2));
        send_item(OP_INSERT, last_keys[0]);
        send_item(OP_INSERT, near_keys[0]);
        send_item(OP_INSERT, last_keys[1]);
        send_item(OP_INSERT, last_keys[2]);
        send_item(OP_INSERT, near_keys[1]);
        send_item(OP_INSERT, last_keys[3]);
        send_item(OP_INSERT, last_keys[2]);
        foreach (last_keys[i])
            key_pool.push_back(last_keys[i]);
        foreach (near_keys[i])
            key_pool.push_back(near_keys[i]);
    endtask

    // Clear ignores its key; a cleared key comes back as new
    task automatic test_clear();
        send_item(OP_CLEAR, EMPTY_KEY);
        send_item(OP_INSERT, 64'h0);
        send_item(OP_CLEAR, rand_key());
        send_item(OP_INSERT, 64'h0);
    endtask

    // Hold the receiver off long enough that the block stops taking input
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_len <= hold_cnt + HOLD_CYCLES;
        repeat (8)
            send_item(OP_INSERT, rand_key());
    endtask

    // Fill to three quarters, then check refusal, reserved-key priority and clear
    task automatic test_load_limit();
        logic [KEY_W-1:0] first_key;
        set_idling(0, 0);
        first_key = rand_key();
        send_item(OP_INSERT, first_key);
        while (shadow_fill < LOAD_LIMIT)
            send_item(OP_INSERT, rand_key());
        send_item(OP_INSERT, first_key);
        send_item(OP_INSERT, rand_key());
        send_item(OP_INSERT, EMPTY_KEY);
        send_item(OP_CLEAR, rand_key());
        send_item(OP_INSERT, first_key);
    endtask

    // Mostly repeated and fresh keys, with a few reserved keys and clears
    task automatic test_random_mix(input int unsigned count);
        int unsigned      pick;
        logic [KEY_W-1:0] k;
        repeat (count)
        begin
            pick = $urandom_range(0, 199);
            if (pick < 2)
                send_item(OP_CLEAR, rand_key());
            else if (pick < 8)
                send_item(OP_INSERT, EMPTY_KEY);
            else if (pick < 90 && key_pool.size() > 0)
                send_item(OP_INSERT, key_pool[$urandom_range(0, key_pool.size() - 1)]);
            else
            begin
                k = (pick < 110) ? KEY_W'($urandom_range(0, 4095)) : rand_key();
                if (key_pool.size() < POOL_MAX)
                    key_pool.push_back(k);
                else
                    key_pool[$urandom_range(0, POOL_MAX - 1)] = k;
                send_item(OP_INSERT, k);
            end
        end
    endtask

    initial
    begin
        foreach (shadow_slots[i])
            shadow_slots[i] = EMPTY_KEY;
        shadow_fill = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        test_extreme_keys();
        test_probe_wrap();
        test_clear();
        test_backpressure();
        test_load_limit();

        set_idling(0, 0);
        test_random_mix(PHASE_ITEMS);
        set_idling(49, 0);
        test_random_mix(PHASE_ITEMS);
        set_idling(0, 49);
        test_random_mix(PHASE_ITEMS);
        set_idling(7, 7);
        test_random_mix(PHASE_ITEMS);

        // Drop valid and let the remaining results drain
        in_valid <= 1'b0;
        set_idling(0, 0);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d operations and %0d checked results, %0d mismatches.",
                 sent_count, checked_count, error_count);
        $display("Inserts: %0d new, %0d found, %0d refused at load; %0d reserved, %0d clears.",
                 new_count, found_count, full_count, reserved_count, clear_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("** open_addressing_hash_set_top: PASSED **");
        else
            $display("** open_addressing_hash_set_top: FAILED **");
        $finish;
    end

endmodule
